>>> rtl/skt_pkg.sv
// skt_pkg: shared types, widths and codes for the sorted key table
// no dependencies; used by skt_cell and sorted_key_table
package skt_pkg;

  // field widths
  localparam int KEY_W        = 31;
  localparam int OP_W         = 2;
  localparam int ST_W         = 2;
  localparam int POS_W        = 11;
  localparam int CAPACITY_DEF = 1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_PRESENT   = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  // token phase while it walks the chain
  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_INS    = 2'd1;
  localparam logic [1:0] PH_DEL    = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_count;
  } rsp_t;

  // operation token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [1:0]       phase;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
  } tok_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic adv;
    logic full;
  } ctrl_t;

endpackage

>>> rtl/skt_cell.sv
// skt_cell: one slot of the sorted key table, holds one key and passes the
// operation token to the next slot; depends on skt_pkg
module skt_cell #(
  parameter int IDX = 0,
  parameter int CW  = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  skt_pkg::ctrl_t            ctrl,
  input  logic [CW-1:0]             count,
  input  skt_pkg::tok_t             tok_in,
  input  logic [skt_pkg::KEY_W-1:0] right_key,
  output skt_pkg::tok_t             tok_out,
  output logic [skt_pkg::KEY_W-1:0] key_q
);

  logic [skt_pkg::KEY_W-1:0] key_next;
  skt_pkg::tok_t             tok_next;
  logic                      occupied;
  logic                      hit;

  assign occupied = count > CW'(IDX);
  assign hit      = occupied && (key_q == tok_in.key);

  // per-slot search, insert shift and delete shift
  always_comb begin
    tok_next = tok_in;
    key_next = key_q;
    if (tok_in.valid) begin
      case (tok_in.phase)
        skt_pkg::PH_SEARCH: begin
          // lower bound lands on the first slot not below the key
          if (!(occupied && (key_q < tok_in.key))) begin
            tok_next.phase    = skt_pkg::PH_DONE;
            tok_next.position = '0;
            case (tok_in.op)
              skt_pkg::OP_INSERT: begin
                if (hit) begin
                  tok_next.status   = skt_pkg::ST_PRESENT;
                  tok_next.position = skt_pkg::POS_W'(IDX);
                end else if (ctrl.full) begin
                  tok_next.status = skt_pkg::ST_FULL;
                end else begin
                  key_next          = tok_in.key;
                  tok_next.key      = key_q;
                  tok_next.status   = skt_pkg::ST_DONE;
                  tok_next.position = skt_pkg::POS_W'(IDX);
                  tok_next.phase    = skt_pkg::PH_INS;
                end
              end
              skt_pkg::OP_DELETE: begin
                if (!hit) begin
                  tok_next.status = skt_pkg::ST_NOT_FOUND;
                end else begin
                  key_next          = right_key;
                  tok_next.status   = skt_pkg::ST_DONE;
                  tok_next.position = skt_pkg::POS_W'(IDX);
                  tok_next.phase    = skt_pkg::PH_DEL;
                end
              end
              default: begin
                if (hit) begin
                  tok_next.status   = skt_pkg::ST_DONE;
                  tok_next.position = skt_pkg::POS_W'(IDX);
                end else begin
                  tok_next.status = skt_pkg::ST_NOT_FOUND;
                end
              end
            endcase
          end
        end
        skt_pkg::PH_INS: begin
          // take the displaced key, hand ours on
          key_next     = tok_in.key;
          tok_next.key = key_q;
        end
        skt_pkg::PH_DEL: begin
          // close the gap from the right neighbor
          key_next = right_key;
        end
        default: begin
        end
      endcase
    end
  end

  // key storage
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      key_q <= key_next;
    end
  end

  // token register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (ctrl.adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> rtl/sorted_key_table.sv
// sorted_key_table: ascending table of distinct keys built as a chain of cells
// depends on skt_pkg and skt_cell
//
// Usage: a request (op, key) is transferred on req when req_valid is high and
// req_stall is low; one response (status, position, entry_count) is
// transferred on rsp when rsp_valid is high and rsp_stall is low.
// op: lookup, insert, delete; a spare code acts as a lookup.
// Each request enters a token that walks the chain of CAPACITY cells, one
// cell per cycle while the chain advances: it searches, shifts keys up on
// insert or down on delete. The token passes the entry register and every
// cell register before the response register; one request is in flight at a
// time, so a new request is taken once the previous response is registered.
// The response register lets the next request enter while a response waits.
// If the receiver still stalls when the next token reaches the chain's end,
// the whole chain holds until the response register frees.
// Reset empties the table (count zero) and drops any request in flight;
// key storage itself is not cleared.
module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  skt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output skt_pkg::rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic                      busy;
  logic                      accept;
  logic                      load;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [skt_pkg::ST_W-1:0]  status;
  logic [skt_pkg::POS_W-1:0] position;
  skt_pkg::ctrl_t            ctrl;
  skt_pkg::tok_t             ent;
  skt_pkg::tok_t             ex;
  skt_pkg::tok_t             tok [CAPACITY+1];
  logic [skt_pkg::KEY_W-1:0] keys [CAPACITY];

  assign req_stall = busy;
  assign accept    = req_valid && !busy;
  assign ex        = tok[CAPACITY];
  assign load      = ex.valid && (!rsp_valid || !rsp_stall);

  // chain moves unless the exiting token cannot be registered
  assign ctrl.adv  = !(ex.valid && rsp_valid && rsp_stall);
  assign ctrl.full = count == CW'(CAPACITY);

  // entry register feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (accept) begin
      ent <= '{valid: 1'b1, phase: skt_pkg::PH_SEARCH, op: req.op, key: req.key,
               status: skt_pkg::ST_DONE, position: '0};
    end else if (ctrl.adv) begin
      ent.valid <= 1'b0;
    end
  end

  assign tok[0] = ent;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [skt_pkg::KEY_W-1:0] right_key;
    if (i == CAPACITY - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_mid
      assign right_key = keys[i+1];
    end
    skt_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .count     (count),
      .tok_in    (tok[i]),
      .right_key (right_key),
      .tok_out   (tok[i+1]),
      .key_q     (keys[i])
    );
  end

  // resolve a token that ran off the end still searching
  always_comb begin
    status   = ex.status;
    position = ex.position;
    if (ex.phase == skt_pkg::PH_SEARCH) begin
      position = '0;
      status   = (ex.op == skt_pkg::OP_INSERT) ? skt_pkg::ST_FULL : skt_pkg::ST_NOT_FOUND;
    end
    count_next = count;
    if (status == skt_pkg::ST_DONE) begin
      if (ex.op == skt_pkg::OP_INSERT) begin
        count_next = count + CW'(1);
      end else if (ex.op == skt_pkg::OP_DELETE) begin
        count_next = count - CW'(1);
      end
    end
  end

  // count, busy and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
      if (load) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status      <= status;
      rsp.position    <= position;
      rsp.entry_count <= skt_pkg::POS_W'(count_next);
    end
  end

`ifndef SYNTHESIS
  // the table never holds more than its capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("key count above capacity");

  // only one token lives in the chain at a time
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    ent.valid |-> !ex.valid)
    else $error("two tokens in the chain");

  // registered entry count matches the updated count
  a_count_report: assert property (@(posedge clk) disable iff (rst)
    load |=> rsp.entry_count == skt_pkg::POS_W'(count))
    else $error("entry count out of step with table");

  // count changes only when a response is loaded, by at most one each time
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !load |=> count == $past(count))
    else $error("count changed without a response");
`endif

endmodule

>>> sim/sorted_key_table_checker.sv
// sorted_key_table_checker: watches both channels of the sorted key table,
// keeps its own ordered copy of the held keys and checks every response
// depends on skt_pkg
module sorted_key_table_checker #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  skt_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  skt_pkg::rsp_t rsp,
  output int            mismatch_count,
  output int            awaited_count
);

  // keys the table should hold, ascending
  logic [skt_pkg::KEY_W-1:0] held_keys[$];
  // responses predicted but not yet transferred, oldest first
  skt_pkg::rsp_t awaited_rsp[$];

  // first position whose key is not below k
  function automatic int lower_bound_of(input logic [skt_pkg::KEY_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = held_keys.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (held_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // update the held keys for one request and return the response it earns
  function automatic skt_pkg::rsp_t apply_request(input skt_pkg::req_t item);
    skt_pkg::rsp_t r;
    int at;
    bit hit;
    at = lower_bound_of(item.key);
    hit = (at < held_keys.size()) && (held_keys[at] == item.key);
    r.status = skt_pkg::ST_NOT_FOUND;
    r.position = '0;
    case (item.op)
      skt_pkg::OP_INSERT: begin
        // duplicate check comes ahead of the fullness check
        if (hit) begin
          r.status = skt_pkg::ST_PRESENT;
          r.position = skt_pkg::POS_W'(at);
        end else if (held_keys.size() >= CAPACITY) begin
          r.status = skt_pkg::ST_FULL;
        end else begin
          held_keys.insert(at, item.key);
          r.status = skt_pkg::ST_DONE;
          r.position = skt_pkg::POS_W'(at);
        end
      end
      skt_pkg::OP_DELETE: begin
        if (hit) begin
          held_keys.delete(at);
          r.status = skt_pkg::ST_DONE;
          r.position = skt_pkg::POS_W'(at);
        end
      end
      default: begin
        // lookup, and the spare code behaves the same way
        if (hit) begin
          r.status = skt_pkg::ST_DONE;
          r.position = skt_pkg::POS_W'(at);
        end
      end
    endcase
    r.entry_count = skt_pkg::POS_W'(held_keys.size());
    return r;
  endfunction

  task automatic flag_field(input string field, input int want_v, input int got_v);
    mismatch_count++;
    $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
  endtask

  // compare each response transfer, then predict for each request transfer
  always @(posedge clk) begin
    skt_pkg::rsp_t want;
    if (rst) begin
      held_keys.delete();
      awaited_rsp.delete();
      awaited_count = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          mismatch_count++;
          $error("response transfer with no request awaiting it");
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.status !== want.status)
            flag_field("status", want.status, rsp.status);
          if (rsp.position !== want.position)
            flag_field("position", want.position, rsp.position);
          if (rsp.entry_count !== want.entry_count)
            flag_field("entry_count", want.entry_count, rsp.entry_count);
        end
      end
      if (req_valid && !req_stall)
        awaited_rsp.insert(awaited_rsp.size(), apply_request(req));
      awaited_count = awaited_rsp.size();
    end
  end

endmodule

>>> sim/tb_sorted_key_table.sv
// tb_sorted_key_table: drives lookups, inserts and deletes into the sorted key
// table with random gaps and stalls, fills it to capacity and gives the verdict
// depends on skt_pkg, sorted_key_table and sorted_key_table_checker
module tb_sorted_key_table;

  localparam int CAPACITY = skt_pkg::CAPACITY_DEF;
  localparam logic [skt_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [skt_pkg::KEY_W-1:0] KEY_MAX = '1;
  localparam int CYCLE_LIMIT = 8_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  skt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  skt_pkg::rsp_t rsp;

  int mismatch_count;
  int awaited_count;
  int cycles = 0;
  // no gaps and no stalls while set
  bit calm = 1'b0;

  // keys the table should hold, only to steer key choices
  bit held[bit [skt_pkg::KEY_W-1:0]];
  logic [skt_pkg::KEY_W-1:0] key_pool[$];

  // receiver state
  bit rsp_took = 1'b0;
  bit stall_drawn = 1'b0;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_key_table #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  sorted_key_table_checker #(.CAPACITY(CAPACITY)) table_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .mismatch_count(mismatch_count),
    .awaited_count (awaited_count)
  );

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: each response draws a random stall, none while calm
  always @(posedge clk) rsp_took <= rsp_valid && !rsp_stall;

  always @(negedge clk) begin
    if (rsp_took) stall_drawn = 1'b0;
    if (rsp_valid && !stall_drawn) begin
      stall_left = calm ? 0 : $urandom_range(0, 7);
      stall_drawn = 1'b1;
    end
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // a key that was inserted at some point, possibly deleted since
  function automatic logic [skt_pkg::KEY_W-1:0] pooled_key();
    if (key_pool.size() == 0) return '0;
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // one request transfer; entered and left at a falling edge
  task automatic send_req(input logic [skt_pkg::OP_W-1:0] code,
                          input logic [skt_pkg::KEY_W-1:0] k);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (code == skt_pkg::OP_INSERT && !held.exists(k) && held.num() < CAPACITY) begin
      held[k] = 1'b1;
      key_pool.insert(key_pool.size(), k);
    end else if (code == skt_pkg::OP_DELETE && held.exists(k)) begin
      held.delete(k);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{op: code, key: k};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off until every predicted response has been transferred
  task automatic drain();
    req_valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    int pick;
    logic [skt_pkg::OP_W-1:0] code;
    logic [skt_pkg::KEY_W-1:0] k;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // empty table, key extremes, duplicate, misses, spare code
    send_req(skt_pkg::OP_LOOKUP, '0);
    send_req(skt_pkg::OP_DELETE, 31'd5);
    send_req(OP_SPARE, 31'd9);
    send_req(skt_pkg::OP_INSERT, KEY_MAX);
    send_req(skt_pkg::OP_INSERT, '0);
    send_req(skt_pkg::OP_INSERT, 31'd1000);
    send_req(skt_pkg::OP_INSERT, 31'd1000);
    send_req(skt_pkg::OP_LOOKUP, '0);
    send_req(skt_pkg::OP_LOOKUP, KEY_MAX);
    send_req(skt_pkg::OP_LOOKUP, 31'd999);
    send_req(OP_SPARE, 31'd1000);
    send_req(skt_pkg::OP_DELETE, '0);
    send_req(skt_pkg::OP_DELETE, KEY_MAX);
    send_req(skt_pkg::OP_INSERT, 31'd500);
    send_req(skt_pkg::OP_INSERT, 31'd2000);
    send_req(skt_pkg::OP_INSERT, 31'd1500);
    send_req(skt_pkg::OP_DELETE, 31'd1000);
    send_req(skt_pkg::OP_LOOKUP, 31'd1500);
    send_req(skt_pkg::OP_INSERT, 31'h5555_5555);
    send_req(skt_pkg::OP_INSERT, 31'h2AAA_AAAA);
    send_req(skt_pkg::OP_DELETE, 31'd3);
    send_req(skt_pkg::OP_INSERT, '0);
    send_req(skt_pkg::OP_LOOKUP, 31'd500);
    drain();

    // mixed traffic, mostly on a narrow key range so hits and duplicates occur
    for (n = 0; n < 40; n++) begin
      if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) k = skt_pkg::KEY_W'($urandom());
      else k = skt_pkg::KEY_W'($urandom_range(0, 31));
      if (pick < 40) code = skt_pkg::OP_INSERT;
      else if (pick < 65) code = skt_pkg::OP_DELETE;
      else if (pick < 90) code = skt_pkg::OP_LOOKUP;
      else code = OP_SPARE;
      send_req(code, k);
    end

    // fill to capacity: mostly fresh keys, a few duplicates, lookups and deletes
    n = 0;
    while (held.num() < CAPACITY) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      n++;
      pick = $urandom_range(0, 99);
      if (pick < 92) send_req(skt_pkg::OP_INSERT, skt_pkg::KEY_W'($urandom()));
      else if (pick < 95) send_req(skt_pkg::OP_INSERT, pooled_key());
      else if (pick < 97) send_req(skt_pkg::OP_LOOKUP, pooled_key());
      else send_req(skt_pkg::OP_DELETE, pooled_key());
    end
    calm = 1'b0;
    drain();

    // full table: refused inserts, duplicates, deletes and refills
    for (n = 0; n < 40; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_req(skt_pkg::OP_INSERT, skt_pkg::KEY_W'($urandom()));
      else if (pick < 45) send_req(skt_pkg::OP_INSERT, pooled_key());
      else if (pick < 65) send_req(skt_pkg::OP_DELETE, pooled_key());
      else if (pick < 85) send_req(skt_pkg::OP_LOOKUP, pooled_key());
      else if (pick < 92) send_req(OP_SPARE, pooled_key());
      else send_req(skt_pkg::OP_LOOKUP, skt_pkg::KEY_W'($urandom()));
    end
    drain();

    // allow for one more pass through the chain in case of a stray response
    repeat (CAPACITY + 16) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
